@@ hdl/tfbi_pkg.sv @@
// Shared types and constants for the trigram file bitmap index.
// Holds the item field widths and the operation codes used by the index unit.
// No dependencies.
`default_nettype none

package tfbi_pkg;

  // Field widths of the input and result items.
  localparam int KEY_W  = 12;
  localparam int FILE_W = 6;

  // Operation codes carried by in_opcode.
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

endpackage : tfbi_pkg

`default_nettype wire

@@ hdl/trigram_file_bitmap_index_unit.sv @@
// Trigram file bitmap index: one membership word per trigram in a synchronous memory.
// Depends on tfbi_pkg for field widths and operation codes.
`default_nettype none

// After reset the block clears the membership memory, one word per cycle, and
// holds in_stall high while it does so. An insert item reads the trigram's word
// in the accept cycle and writes it back in the next cycle with the file bit
// set; an out-of-range key skips the write, and an out-of-range file number
// sets no bit. A query item reads the word in the accept cycle, loads it for
// scanning in the lookup state, then puts one result per cycle into the output
// register while out_stall is low: n results for a word with n bits set, or a
// single empty result, which an out-of-range key also gives. The membership
// memory has one write port and one registered read port. The next item is
// accepted once the last result of a query is in the output register, even
// while that result still waits to be taken.
module trigram_file_bitmap_index_unit
  import tfbi_pkg::*;
#(
  parameter int TRIGRAM_COUNT = 4096,
  parameter int FILE_SLOTS    = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input item channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_opcode,
  input  wire logic [FILE_W-1:0] in_file_number,
  input  wire logic [KEY_W-1:0]  in_trigram_key,
  // Result item channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [FILE_W-1:0]      out_found_file,
  output logic                   out_last_of_run,
  output logic                   out_run_empty
);

  localparam int AW = (TRIGRAM_COUNT > 1) ? $clog2(TRIGRAM_COUNT) : 1;
  localparam int CW = ((AW > KEY_W) ? AW : KEY_W) + 1;
  localparam int MF = FILE_SLOTS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     clr_addr_r;
  logic [AW-1:0]     addr_r;
  logic              is_query_r;
  logic              key_ok_r;
  logic              file_ok_r;
  logic [FILE_W-1:0] file_r;
  logic [MF-1:0]     scan_r;
  logic              out_valid_r;
  logic [FILE_W-1:0] out_file_r;
  logic              out_last_r;
  logic              out_empty_r;

  // Membership memory and its ports.
  logic [MF-1:0]     mem [TRIGRAM_COUNT];
  logic [MF-1:0]     rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [MF-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic              in_accept;
  logic [CW-1:0]     key_ext;
  logic              key_ok;
  logic              file_ok;
  logic [MF-1:0]     set_mask;
  logic [MF-1:0]     low_bit;
  logic [MF-1:0]     scan_rest;
  logic [FILE_W-1:0] low_idx;
  logic              out_load;
  logic              emit_last;

  // Handshake and input decode.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign key_ext   = CW'(in_trigram_key);
  assign key_ok    = (key_ext < CW'(TRIGRAM_COUNT));
  assign file_ok   = ({1'b0, in_file_number} < (FILE_W + 1)'(FILE_SLOTS));
  assign mem_raddr = AW'(key_ext);

  // Write port: the clearing pass, or the write-back half of an insert.
  always_comb begin
    set_mask = '0;
    if (file_ok_r) begin
      set_mask = MF'(1) << file_r;
    end
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = rd_data_r | set_mask;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == ST_LOOKUP && !is_query_r && key_ok_r) begin
      mem_we = 1'b1;
    end
  end

  // Memory: one write and one registered read per cycle. The state machine
  // accepts no item until an insert's write-back is done, so a read never
  // overtakes a pending write to the same word.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Lowest set bit of the remaining query word and its file id.
  always_comb begin
    low_bit   = scan_r & (~scan_r + MF'(1));
    scan_rest = scan_r & ~low_bit;
    low_idx   = '0;
    for (int i = 0; i < MF; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | FILE_W'(i);
      end
    end
  end

  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign emit_last = (scan_rest == '0);

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result leaves the register unless the next one replaces it.
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(TRIGRAM_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (is_query_r) begin
            scan_r  <= key_ok_r ? rd_data_r : '0;
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_file_r  <= low_idx;
            out_last_r  <= emit_last;
            out_empty_r <= (scan_r == '0);
            scan_r      <= scan_rest;
            if (emit_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Item capture at accept.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_r     <= mem_raddr;
      is_query_r <= (in_opcode == OP_QUERY);
      key_ok_r   <= key_ok;
      file_ok_r  <= file_ok;
      file_r     <= in_file_number;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found_file  = out_file_r;
  assign out_last_of_run = out_last_r;
  assign out_run_empty   = out_empty_r;

`ifndef SYNTHESIS
  // An empty result closes its query and carries file id zero.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_empty |-> out_last_of_run && (out_found_file == '0))
    else $error("empty result without last flag or with nonzero file id");

  // An accepted item always goes to the memory lookup next.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_LOOKUP)
    else $error("accepted item did not start a lookup");

  // Emitting the final result of a query returns the unit to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && emit_last |=> state_r == ST_IDLE)
    else $error("query did not finish after its last result");

  // A taken result that is not the last is followed at once by the next one.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("query run broke off before its last result");
`endif

endmodule : trigram_file_bitmap_index_unit

`default_nettype wire
